FILE: src/adaptive_two_bit_branch_predictor_defines.svh
// Assertion macros shared by the branch predictor modules.
`ifndef ADAPTIVE_TWO_BIT_BRANCH_PREDICTOR_DEFINES_SVH
`define ADAPTIVE_TWO_BIT_BRANCH_PREDICTOR_DEFINES_SVH

`ifndef SYNTHESIS

`define ABP_ASSERT(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed: expression does not hold");

`define ABP_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication does not hold");

`define ABP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication does not hold");

`else

`define ABP_ASSERT(label, expr)
`define ABP_ASSERT_IMPLY(label, ante, cons)
`define ABP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: src/abp_pkg.sv
// Types and constants of the adaptive two-bit branch predictor.
package abp_pkg;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 21;

   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_BITS_USED = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_STATE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REMAP_PERIOD    = 2'd2;

   localparam logic [3:0]  RESET_INDEX_BITS  = 4'd10;
   localparam logic [1:0]  RESET_INIT_STATE  = 2'd0;
   localparam logic [20:0] RESET_PERIOD      = 21'd1024;
   localparam logic [20:0] PERIOD_MAX        = 21'd1048576;

   // Prediction per counter state, state 3 in the top bit.
   localparam logic [3:0]  MAP_RESET         = 4'b1100;
   localparam logic [1:0]  STATE_TOP         = 2'd3;
   localparam logic [1:0]  STATE_BOTTOM      = 2'd0;

   typedef struct packed {
      logic [63:0] branch_pc;
      logic        actual_taken;
   } req_word_type;

   typedef struct packed {
      logic        predicted_taken;
      logic        mispredicted;
      logic [31:0] total_mispredicts;
      logic [31:0] total_branches;
   } rsp_word_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } ctrl_state_type;

   typedef struct packed {
      logic clear_write;
      logic accept;
      logic commit;
   } abp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
   } abp_status_type;

endpackage

FILE: src/abp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module abp_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/abp_ctrl.sv
// Controller state machine: clearing pass, word acceptance and commit.
`include "adaptive_two_bit_branch_predictor_defines.svh"
module abp_ctrl
   import abp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  abp_status_type status,
   output abp_cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_write = 1'b1;
         end
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_LOOKUP: begin
            cmd.commit = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   `ABP_ASSERT_NEXT(a_accept_to_lookup, cmd.accept, state_ff == ST_LOOKUP)
   `ABP_ASSERT(a_one_command, $onehot0(cmd))

endmodule

FILE: src/abp_dpath.sv
// Datapath: configuration, counter table, outcome histogram, map and totals.
`include "adaptive_two_bit_branch_predictor_defines.svh"
module abp_dpath
   import abp_pkg::*;
#(
   parameter int INDEX_BITS = 10,
   parameter int COUNT_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  abp_cmd_type            cmd,
   output abp_status_type         status,
   input  req_word_type           req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_word_type           rsp_word,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int DEPTH = 2 ** INDEX_BITS;
   localparam logic [4:0] IDX_MAX = 5'(INDEX_BITS);

   logic [3:0]            cfg_index_bits_ff;
   logic [1:0]            cfg_init_state_ff;
   logic [20:0]           cfg_period_ff;

   logic [INDEX_BITS-1:0] clear_addr_ff;
   logic [INDEX_BITS-1:0] index_ff;
   logic                  taken_ff;
   logic [3:0]            map_ff;
   logic [3:0]            map_in;
   logic [19:0]           position_ff;
   logic [19:0]           position_in;
   logic [COUNT_BITS-1:0] hist_ff [8];
   logic [COUNT_BITS-1:0] hist_in [8];
   logic [31:0]           branch_total_ff;
   logic [31:0]           branch_total_in;
   logic [31:0]           miss_total_ff;
   logic [31:0]           miss_total_in;
   logic                  rsp_valid_ff;
   rsp_word_type          rsp_word_ff;

   logic [4:0]            bits_eff;
   logic [INDEX_BITS-1:0] index_mask;
   logic [INDEX_BITS-1:0] req_index;
   logic [20:0]           period_eff;
   logic                  wrap;

   logic                  ram_wr_en;
   logic [INDEX_BITS-1:0] ram_wr_addr;
   logic [2:0]            ram_wr_data;
   logic [INDEX_BITS-1:0] ram_rd_addr;
   logic [2:0]            ram_rd_data;

   logic [1:0]            cur_state;
   logic [1:0]            new_state;
   logic [2:0]            bin;
   logic                  pred;
   logic                  miss;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_index_bits_ff <= RESET_INDEX_BITS;
         cfg_init_state_ff <= RESET_INIT_STATE;
         cfg_period_ff     <= RESET_PERIOD;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_INDEX_BITS_USED: cfg_index_bits_ff <= csr_wdata[3:0];
            CSR_INITIAL_STATE:   cfg_init_state_ff <= csr_wdata[1:0];
            CSR_REMAP_PERIOD:    cfg_period_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Index width and period, clamped to their legal ranges.
   always_comb begin
      if (cfg_index_bits_ff == 4'd0) begin
         bits_eff = 5'd1;
      end else if ({1'b0, cfg_index_bits_ff} > IDX_MAX) begin
         bits_eff = IDX_MAX;
      end else begin
         bits_eff = {1'b0, cfg_index_bits_ff};
      end
      if (cfg_period_ff == 21'd0) begin
         period_eff = 21'd1;
      end else if (cfg_period_ff > PERIOD_MAX) begin
         period_eff = PERIOD_MAX;
      end else begin
         period_eff = cfg_period_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < INDEX_BITS; i++) begin
         index_mask[i] = (5'(i) < bits_eff);
      end
   end

   assign req_index = req_word.branch_pc[INDEX_BITS-1:0] & index_mask;
   assign wrap      = ({1'b0, position_ff} + 21'd1) >= period_eff;

   // Map rebuild happens at acceptance, before the histogram sees this word.
   always_comb begin
      map_in      = map_ff;
      position_in = position_ff;
      if (cmd.accept) begin
         if (wrap) begin
            position_in = '0;
            for (int s = 0; s < 4; s++) begin
               if (hist_ff[2*s+1] > hist_ff[2*s]) begin
                  map_in[s] = 1'b1;
               end else if (hist_ff[2*s+1] < hist_ff[2*s]) begin
                  map_in[s] = 1'b0;
               end
            end
         end else begin
            position_in = position_ff + 20'd1;
         end
      end
   end

   // An entry never written since the clearing pass reads as the initial state.
   assign cur_state = ram_rd_data[2] ? ram_rd_data[1:0] : cfg_init_state_ff;
   assign bin       = {cur_state, taken_ff};
   assign pred      = map_ff[cur_state];
   assign miss      = pred ^ taken_ff;

   always_comb begin
      new_state = cur_state;
      if (taken_ff) begin
         if (cur_state != STATE_TOP) begin
            new_state = cur_state + 2'd1;
         end
      end else if (cur_state != STATE_BOTTOM) begin
         new_state = cur_state - 2'd1;
      end
   end

   always_comb begin
      for (int b = 0; b < 8; b++) begin
         hist_in[b] = hist_ff[b];
         if (cmd.commit && (bin == 3'(b)) && (hist_ff[b] != '1)) begin
            hist_in[b] = hist_ff[b] + COUNT_BITS'(1);
         end
      end
      branch_total_in = branch_total_ff;
      miss_total_in   = miss_total_ff;
      if (cmd.commit) begin
         if (branch_total_ff != '1) begin
            branch_total_in = branch_total_ff + 32'd1;
         end
         if (miss && (miss_total_ff != '1)) begin
            miss_total_in = miss_total_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff   <= '0;
         map_ff          <= MAP_RESET;
         position_ff     <= '0;
         branch_total_ff <= '0;
         miss_total_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
         for (int b = 0; b < 8; b++) begin
            hist_ff[b] <= '0;
         end
      end else begin
         if (cmd.clear_write) begin
            clear_addr_ff <= clear_addr_ff + INDEX_BITS'(1);
         end
         map_ff          <= map_in;
         position_ff     <= position_in;
         branch_total_ff <= branch_total_in;
         miss_total_ff   <= miss_total_in;
         for (int b = 0; b < 8; b++) begin
            hist_ff[b] <= hist_in[b];
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         index_ff <= req_index;
         taken_ff <= req_word.actual_taken;
      end
      if (cmd.commit) begin
         rsp_word_ff.predicted_taken   <= pred;
         rsp_word_ff.mispredicted      <= miss;
         rsp_word_ff.total_mispredicts <= miss_total_in;
         rsp_word_ff.total_branches    <= branch_total_in;
      end
   end

   // Table entry: valid bit above the two-bit counter.
   always_comb begin
      ram_wr_en   = cmd.clear_write | cmd.commit;
      ram_wr_addr = cmd.clear_write ? clear_addr_ff : index_ff;
      ram_wr_data = cmd.clear_write ? 3'b000 : {1'b1, new_state};
      ram_rd_addr = cmd.accept ? req_index : index_ff;
   end

   abp_ram #(
      .WIDTH (3),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign status.clear_last = (clear_addr_ff == '1);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_word          = rsp_word_ff;

   `ABP_ASSERT_IMPLY(a_commit_needs_room, cmd.commit, !rsp_valid_ff || !rsp_stall)
   `ABP_ASSERT_NEXT(a_commit_loads_output, cmd.commit, rsp_valid_ff)

endmodule

FILE: src/adaptive_two_bit_branch_predictor.sv
// Top level of the adaptive two-bit branch predictor.
//
//   port group   direction   handshake              word
//   req_         in          req_valid / req_stall  req_word_type (pc, outcome)
//   rsp_         out         rsp_valid / rsp_stall  rsp_word_type (prediction, totals)
//   csr_         in          csr_write_en           csr_index, csr_wdata
//
// Words are handled one at a time: the accept cycle reads the counter table
// RAM, and the lookup state after it updates histogram, totals and counter
// and writes the entry back. After reset a clearing pass marks every table
// entry unwritten; req_stall stays high during it, configuration writes are taken.
// A result waits in the output register; a stalled rsp_ side holds the next
// word in its update cycle until that register frees up.
module adaptive_two_bit_branch_predictor
   import abp_pkg::*;
#(
   parameter int INDEX_BITS = 10,
   parameter int COUNT_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_word_type           req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_word_type           rsp_word,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   abp_cmd_type    cmd;
   abp_status_type status;

   abp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   abp_dpath #(
      .INDEX_BITS (INDEX_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_word     (req_word),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_word     (rsp_word),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

endmodule
